FILE: hdl/aes256_key_candidate_test_assert.svh
// Assertion macros for the AES-256 key candidate tester
`ifndef AES256_KEY_CANDIDATE_TEST_ASSERT_SVH
`define AES256_KEY_CANDIDATE_TEST_ASSERT_SVH
`ifndef ASSERT_OFF
`define AKC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define AKC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define AKC_ASSERT(lbl, prop)
`define AKC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/aeskct_pkg.sv
// Types, tables and AES helper functions for the key candidate tester
package aeskct_pkg;

  localparam int unsigned MASK_LEN   = 255;
  localparam int unsigned PIPE_DEPTH = 29;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A_OFS = 8'h57;
  localparam logic [3:0] HEX_TEN     = 4'ha;

  typedef enum logic [1:0] {
    CFG_CIPHER_HIGH = 2'd0,
    CFG_CIPHER_LOW  = 2'd1,
    CFG_KEY_FORMAT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] counter_value;
    logic [7:0]  mask_index;
  } in_t;

  typedef struct packed {
    logic        is_match;
    logic [31:0] echo_counter;
    logic [7:0]  echo_index;
    logic [63:0] masked_key_0;
    logic [63:0] masked_key_1;
    logic [63:0] masked_key_2;
    logic [63:0] masked_key_3;
  } out_t;

  typedef logic [7:0][31:0] kwin_t;
  typedef logic [15:0][7:0] blk_t;

  localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

  localparam logic [7:0] MASK_TABLE [MASK_LEN] = '{
    8'h8a, 8'h5c, 8'h6a, 8'hdd, 8'h1f, 8'hea, 8'h6e, 8'he2, 8'h10, 8'hfc, 8'h3c, 8'h58,
    8'h55, 8'hd2, 8'h09, 8'hb8, 8'hd4, 8'ha7, 8'h3e, 8'hc9, 8'hdc, 8'hd9, 8'h20, 8'he5,
    8'h78, 8'hb0, 8'haa, 8'hb9, 8'h12, 8'h6d, 8'hb5, 8'h53, 8'h7c, 8'h8f, 8'ha5, 8'haf,
    8'h40, 8'hd7, 8'hf0, 8'h7d, 8'h49, 8'h6f, 8'h24, 8'hda, 8'h77, 8'ha6, 8'hf8, 8'h03,
    8'h57, 8'h43, 8'h80, 8'hb3, 8'hfd, 8'hfa, 8'h92, 8'hde, 8'h48, 8'ha9, 8'hee, 8'h51,
    8'hed, 8'h06, 8'hae, 8'h86, 8'h1d, 8'h7b, 8'he7, 8'he9, 8'h39, 8'ha1, 8'h90, 8'h4f,
    8'hc1, 8'ha2, 8'hc7, 8'h0c, 8'h41, 8'h11, 8'h3a, 8'hf6, 8'hd3, 8'hcf, 8'h72, 8'h5f,
    8'h3d, 8'h9e, 8'h9f, 8'h59, 8'h93, 8'h18, 8'h82, 8'h22, 8'h74, 8'hf1, 8'hbb, 8'h83,
    8'he4, 8'hbe, 8'h7a, 8'h21, 8'h23, 8'hb2, 8'h3b, 8'h30, 8'h19, 8'h44, 8'he8, 8'hff,
    8'h6b, 8'h1b, 8'hd5, 8'h61, 8'hf4, 8'h42, 8'h46, 8'h79, 8'h76, 8'h60, 8'h32, 8'h88,
    8'hcd, 8'he3, 8'hd6, 8'h36, 8'hb7, 8'hc2, 8'hf5, 8'h84, 8'h8c, 8'hf2, 8'hec, 8'hc0,
    8'h64, 8'h0d, 8'h87, 8'hdb, 8'hb1, 8'h6c, 8'h73, 8'h99, 8'hf7, 8'h15, 8'h05, 8'hf9,
    8'hc5, 8'h9d, 8'hc8, 8'h1a, 8'h13, 8'hab, 8'h7f, 8'hd8, 8'he6, 8'h2f, 8'hf3, 8'h2a,
    8'h0a, 8'hef, 8'h97, 8'h27, 8'h8d, 8'h34, 8'h26, 8'h4b, 8'hfe, 8'had, 8'hd1, 8'h5e,
    8'hfb, 8'h54, 8'h14, 8'hc3, 8'h33, 8'h4e, 8'h07, 8'h68, 8'h4c, 8'h96, 8'he1, 8'h47,
    8'hbf, 8'hbc, 8'heb, 8'ha8, 8'h28, 8'h9b, 8'h66, 8'h9c, 8'h0e, 8'hd0, 8'h98, 8'h31,
    8'hdf, 8'h8e, 8'h63, 8'h65, 8'hcb, 8'h4d, 8'h50, 8'h2b, 8'hcc, 8'h25, 8'h1c, 8'hbd,
    8'h2d, 8'h62, 8'ha3, 8'h01, 8'hc6, 8'hca, 8'h8b, 8'h9a, 8'ha0, 8'h56, 8'h85, 8'h4a,
    8'h38, 8'h67, 8'h5a, 8'hc4, 8'h5b, 8'h02, 8'h91, 8'h89, 8'h0b, 8'h29, 8'h5d, 8'hac,
    8'h17, 8'h94, 8'h70, 8'hce, 8'hb4, 8'h95, 8'hb6, 8'h04, 8'h3f, 8'h0f, 8'h16, 8'h52,
    8'hba, 8'h45, 8'h2e, 8'h35, 8'he0, 8'h81, 8'h75, 8'h37, 8'h71, 8'h08, 8'h7e, 8'h1e,
    8'h2c, 8'ha4, 8'h69
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] aff_inv(input logic [7:0] b);
    return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ 8'h05;
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return aff_inv(SBOX[aff_inv(x)]);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] rot_word(input logic [31:0] w);
    return {w[23:0], w[31:24]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t rk_blk(input logic [3:0][31:0] k);
    blk_t b;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        b[4*c + r] = k[c][31 - 8*r -: 8];
      end
    end
    return b;
  endfunction

  function automatic blk_t inv_shift_sub(input blk_t s);
    blk_t o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[r + 4*c] = inv_sbox(s[r + 4*((c + 4 - r) & 3)]);
      end
    end
    return o;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t o;
    logic [3:0][7:0] a, x2, x4, x8, m9, m11, m13, m14;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]   = s[4*c + r];
        x2[r]  = xtime(a[r]);
        x4[r]  = xtime(x2[r]);
        x8[r]  = xtime(x4[r]);
        m9[r]  = x8[r] ^ a[r];
        m11[r] = x8[r] ^ x2[r] ^ a[r];
        m13[r] = x8[r] ^ x4[r] ^ a[r];
        m14[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      o[4*c]     = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      o[4*c + 1] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      o[4*c + 2] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      o[4*c + 3] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return o;
  endfunction

endpackage

FILE: hdl/aeskct_key_fwd.sv
// One forward key-expansion stage: four new schedule words per cycle
module aeskct_key_fwd #(
  parameter int unsigned STEP = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  aeskct_pkg::in_t    tag_i,
  input  aeskct_pkg::kwin_t  win_i,
  output logic               valid_o,
  output aeskct_pkg::in_t    tag_o,
  output aeskct_pkg::kwin_t  win_o
);
  import aeskct_pkg::*;

  localparam bit          RotStep = (STEP % 2) == 1;
  localparam int unsigned RconIdx = (STEP + 1) / 2 - 1;

  logic        valid_q;
  in_t         tag_q;
  kwin_t       win_q, win_d;
  logic [31:0] t, n0, n1, n2, n3;

  always_comb begin
    if (RotStep) begin
      t = sub_word(rot_word(win_i[7])) ^ {RCON[RconIdx], 24'h0};
    end else begin
      t = sub_word(win_i[7]);
    end
    n0    = win_i[0] ^ t;
    n1    = win_i[1] ^ n0;
    n2    = win_i[2] ^ n1;
    n3    = win_i[3] ^ n2;
    win_d = {n3, n2, n1, n0, win_i[7], win_i[6], win_i[5], win_i[4]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_i;
    win_q <= win_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign win_o   = win_q;

endmodule

FILE: hdl/aeskct_dec_round.sv
// One inverse cipher round with the key schedule stepped backward alongside
module aeskct_dec_round #(
  parameter int unsigned ROUND = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  aeskct_pkg::in_t    tag_i,
  input  aeskct_pkg::kwin_t  win_i,
  input  aeskct_pkg::blk_t   state_i,
  output logic               valid_o,
  output aeskct_pkg::in_t    tag_o,
  output aeskct_pkg::kwin_t  win_o,
  output aeskct_pkg::blk_t   state_o
);
  import aeskct_pkg::*;

  localparam bit          RotStep = (ROUND % 2) == 1;
  localparam int unsigned RconIdx = (ROUND + 1) / 2 - 1;

  logic        valid_q;
  in_t         tag_q;
  kwin_t       win_q, win_d;
  blk_t        state_q, state_d;
  logic [31:0] t, b0, b1, b2, b3;

  always_comb begin
    if (RotStep) begin
      t = sub_word(rot_word(win_i[3])) ^ {RCON[RconIdx], 24'h0};
    end else begin
      t = sub_word(win_i[3]);
    end
    b0      = win_i[4] ^ t;
    b1      = win_i[5] ^ win_i[4];
    b2      = win_i[6] ^ win_i[5];
    b3      = win_i[7] ^ win_i[6];
    win_d   = {win_i[3], win_i[2], win_i[1], win_i[0], b3, b2, b1, b0};
    state_d = inv_mix(inv_shift_sub(state_i) ^ rk_blk(win_i[3:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_i;
    win_q   <= win_d;
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign win_o   = win_q;
  assign state_o = state_q;

endmodule

FILE: hdl/aes256_key_candidate_test.sv
// Top level: key build, AES-256 key expansion and decryption pipeline
//
// Takes one candidate (counter, mask index) in every cycle and produces its
// result on done_o/result_o, one result per accepted start. The pipeline is
// the key build stage, 13 key-expansion stages that run the
// schedule forward to the last round keys, and 15 decryption stages that
// step the schedule back while applying each round. busy_o stays low, and
// results cannot be held off. Write the configuration only while no
// candidate is in flight.
module aes256_key_candidate_test (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  aeskct_pkg::in_t   item_i,
  output logic              done_o,
  output aeskct_pkg::out_t  result_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i
);
  import aeskct_pkg::*;

  `include "aes256_key_candidate_test_assert.svh"

  localparam int unsigned FwdSteps = 13;

  logic [63:0] cipher_high_q, cipher_low_q;
  logic        key_format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_high_q <= '0;
      cipher_low_q  <= '0;
      key_format_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CIPHER_HIGH: cipher_high_q <= cfg_data_i;
        CFG_CIPHER_LOW:  cipher_low_q  <= cfg_data_i;
        CFG_KEY_FORMAT:  key_format_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // key build and mask
  kwin_t       key_d;
  logic [7:0]  kbyte;
  logic [3:0]  nib;
  logic [8:0]  mpos;

  always_comb begin
    key_d = '0;
    kbyte = '0;
    nib   = '0;
    mpos  = '0;
    for (int i = 0; i < 32; i++) begin
      nib = item_i.counter_value[31 - 4*(i & 7) -: 4];
      if (key_format_q) begin
        kbyte = item_i.counter_value[31 - 8*(i & 3) -: 8];
      end else if (nib < HEX_TEN) begin
        kbyte = ASCII_ZERO + {4'h0, nib};
      end else begin
        kbyte = ASCII_A_OFS + {4'h0, nib};
      end
      mpos = {1'b0, item_i.mask_index} + 9'd31 - 9'(i);
      if (mpos >= 9'(MASK_LEN)) begin
        mpos = mpos - 9'(MASK_LEN);
      end
      key_d[i >> 2][31 - 8*(i & 3) -: 8] = kbyte ^ MASK_TABLE[mpos[7:0]];
    end
  end

  logic  fwd_valid [FwdSteps+1];
  in_t   fwd_tag   [FwdSteps+1];
  kwin_t fwd_win   [FwdSteps+1];

  logic  kb_valid_q;
  in_t   kb_tag_q;
  kwin_t kb_win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kb_valid_q <= 1'b0;
    end else begin
      kb_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    kb_tag_q <= item_i;
    kb_win_q <= key_d;
  end

  assign fwd_valid[0] = kb_valid_q;
  assign fwd_tag[0]   = kb_tag_q;
  assign fwd_win[0]   = kb_win_q;

  for (genvar k = 1; k <= FwdSteps; k++) begin : g_fwd
    aeskct_key_fwd #(.STEP(k)) u_fwd (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (fwd_valid[k-1]),
      .tag_i   (fwd_tag[k-1]),
      .win_i   (fwd_win[k-1]),
      .valid_o (fwd_valid[k]),
      .tag_o   (fwd_tag[k]),
      .win_o   (fwd_win[k])
    );
  end

  // initial round key addition
  blk_t  cipher_blk;
  logic  ark_valid_q;
  in_t   ark_tag_q;
  kwin_t ark_win_q;
  blk_t  ark_state_q;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      cipher_blk[n]     = cipher_high_q[63 - 8*n -: 8];
      cipher_blk[8 + n] = cipher_low_q[63 - 8*n -: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ark_valid_q <= 1'b0;
    end else begin
      ark_valid_q <= fwd_valid[FwdSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    ark_tag_q   <= fwd_tag[FwdSteps];
    ark_win_q   <= fwd_win[FwdSteps];
    ark_state_q <= cipher_blk ^ rk_blk(fwd_win[FwdSteps][7:4]);
  end

  logic  rnd_valid [FwdSteps+1];
  in_t   rnd_tag   [FwdSteps+1];
  kwin_t rnd_win   [FwdSteps+1];
  blk_t  rnd_state [FwdSteps+1];

  assign rnd_valid[0] = ark_valid_q;
  assign rnd_tag[0]   = ark_tag_q;
  assign rnd_win[0]   = ark_win_q;
  assign rnd_state[0] = ark_state_q;

  for (genvar r = 0; r < FwdSteps; r++) begin : g_rnd
    aeskct_dec_round #(.ROUND(FwdSteps - r)) u_rnd (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rnd_valid[r]),
      .tag_i   (rnd_tag[r]),
      .win_i   (rnd_win[r]),
      .state_i (rnd_state[r]),
      .valid_o (rnd_valid[r+1]),
      .tag_o   (rnd_tag[r+1]),
      .win_o   (rnd_win[r+1]),
      .state_o (rnd_state[r+1])
    );
  end

  // last round, zero test and result register
  blk_t  last_state;
  logic  done_q;
  out_t  result_q, result_d;
  kwin_t kw;

  always_comb begin
    kw         = rnd_win[FwdSteps];
    last_state = inv_shift_sub(rnd_state[FwdSteps]) ^ rk_blk(kw[3:0]);
    result_d.is_match     = (last_state == '0);
    result_d.echo_counter = rnd_tag[FwdSteps].counter_value;
    result_d.echo_index   = rnd_tag[FwdSteps].mask_index;
    result_d.masked_key_0 = {kw[0], kw[1]};
    result_d.masked_key_1 = {kw[2], kw[3]};
    result_d.masked_key_2 = {kw[4], kw[5]};
    result_d.masked_key_3 = {kw[6], kw[7]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rnd_valid[FwdSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `AKC_ASSERT(a_done_latency, start_i |-> ##PIPE_DEPTH done_o)
  `AKC_ASSERT(a_echo_counter, start_i |-> ##PIPE_DEPTH (result_o.echo_counter == $past(item_i.counter_value, PIPE_DEPTH)))
  `AKC_ASSERT(a_echo_index, start_i |-> ##PIPE_DEPTH (result_o.echo_index == $past(item_i.mask_index, PIPE_DEPTH)))
  `AKC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o)

endmodule

FILE: tb/aes256_key_candidate_test_model_pkg.sv
// Bit-accurate AES-256 candidate key arithmetic used by the testbench
`timescale 1ns / 100ps
package aes256_key_candidate_test_model_pkg;
  import aeskct_pkg::*;

  typedef logic [0:31][7:0]  cand_key_t;
  typedef logic [0:15][7:0]  aes_state_t;
  typedef logic [0:239][7:0] round_keys_t;

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[0]) p = p ^ a;
      a = gf_double(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_recip(logic [7:0] a);
    logic [7:0] r, base;
    logic [7:0] e;
    r = 8'h01;
    base = a;
    e = 8'd254;
    for (int n = 0; n < 8; n++) begin
      if (e[n]) r = gf_mul(r, base);
      base = gf_mul(base, base);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] b;
    b = gf_recip(x);
    return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(logic [7:0] x);
    return gf_recip(rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05);
  endfunction

  function automatic round_keys_t expand_schedule(cand_key_t key);
    round_keys_t rk;
    logic [7:0] t [4];
    logic [7:0] rcon, f;
    rk = '0;
    rcon = 8'h01;
    for (int i = 0; i < 32; i++) rk[i] = key[i];
    for (int i = 8; i < 60; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1) + j];
      if (i % 8 == 0) begin
        f = t[0];
        t[0] = fwd_sub(t[1]) ^ rcon;
        t[1] = fwd_sub(t[2]);
        t[2] = fwd_sub(t[3]);
        t[3] = fwd_sub(f);
        rcon = gf_double(rcon);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) t[j] = fwd_sub(t[j]);
      end
      for (int j = 0; j < 4; j++) rk[4*i + j] = rk[4*(i-8) + j] ^ t[j];
    end
    return rk;
  endfunction

  function automatic aes_state_t add_key(aes_state_t s, round_keys_t rk, int rnd);
    for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*rnd + i];
    return s;
  endfunction

  function automatic aes_state_t shift_sub_fwd(aes_state_t s);
    aes_state_t o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) o[r + 4*c] = fwd_sub(s[r + 4*((c + r) & 3)]);
    return o;
  endfunction

  function automatic aes_state_t shift_sub_rev(aes_state_t s);
    aes_state_t o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) o[r + 4*c] = rev_sub(s[r + 4*((c + 4 - r) & 3)]);
    return o;
  endfunction

  function automatic aes_state_t mix_cols(aes_state_t s, logic [7:0] m0, logic [7:0] m1,
                                          logic [7:0] m2, logic [7:0] m3);
    aes_state_t o;
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[4*c + r];
      for (int r = 0; r < 4; r++)
        o[4*c + r] = gf_mul(a[r], m0) ^ gf_mul(a[(r+1)%4], m1) ^
                     gf_mul(a[(r+2)%4], m2) ^ gf_mul(a[(r+3)%4], m3);
    end
    return o;
  endfunction

  function automatic aes_state_t decrypt_block(cand_key_t key, aes_state_t s);
    round_keys_t rk;
    rk = expand_schedule(key);
    s = add_key(s, rk, 14);
    for (int rnd = 13; rnd >= 1; rnd--) begin
      s = shift_sub_rev(s);
      s = add_key(s, rk, rnd);
      s = mix_cols(s, 8'd14, 8'd11, 8'd13, 8'd9);
    end
    s = shift_sub_rev(s);
    return add_key(s, rk, 0);
  endfunction

  function automatic aes_state_t encrypt_block(cand_key_t key, aes_state_t s);
    round_keys_t rk;
    rk = expand_schedule(key);
    s = add_key(s, rk, 0);
    for (int rnd = 1; rnd <= 13; rnd++) begin
      s = shift_sub_fwd(s);
      s = mix_cols(s, 8'd2, 8'd3, 8'd1, 8'd1);
      s = add_key(s, rk, rnd);
    end
    s = shift_sub_fwd(s);
    return add_key(s, rk, 14);
  endfunction

  function automatic cand_key_t masked_key(logic [31:0] ctr, logic [7:0] idx, logic fmt);
    cand_key_t key;
    logic [3:0] nib;
    logic [7:0] b;
    for (int i = 0; i < 32; i++) begin
      if (fmt) begin
        b = ctr[24 - 8*(i % 4) +: 8];
      end else begin
        nib = ctr[28 - 4*(i % 8) +: 4];
        b = (nib < 4'ha) ? {4'h0, nib} + 8'h30 : {4'h0, nib} + 8'h57;
      end
      key[i] = b ^ MASK_TABLE[(int'(idx) + 31 - i) % 255];
    end
    return key;
  endfunction

  function automatic out_t grade_candidate(logic [31:0] ctr, logic [7:0] idx, logic fmt,
                                           aes_state_t cipher);
    out_t r;
    cand_key_t key;
    key = masked_key(ctr, idx, fmt);
    r.is_match = (decrypt_block(key, cipher) == '0);
    r.echo_counter = ctr;
    r.echo_index = idx;
    r.masked_key_0 = key[0:7];
    r.masked_key_1 = key[8:15];
    r.masked_key_2 = key[16:23];
    r.masked_key_3 = key[24:31];
    return r;
  endfunction
endpackage

FILE: tb/aes256_key_candidate_test_checker.sv
// Result checker: predicts each candidate's outcome and compares the block's output
`timescale 1ns / 100ps
module aes256_key_candidate_test_checker
  import aeskct_pkg::*;
  import aes256_key_candidate_test_model_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_t         item_i,
  input  logic        done_i,
  input  out_t        result_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          match_count_o
);
  out_t       outcome_q [$];
  aes_state_t cipher_cfg;
  logic       format_cfg;
  int         mismatches;
  int         match_total;

  assign fail_count_o  = mismatches;
  assign pending_o     = outcome_q.size();
  assign match_count_o = match_total;

  task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %h got %h", $realtime, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      cipher_cfg = '0;
      format_cfg = 1'b0;
      mismatches = 0;
      match_total = 0;
      outcome_q.delete();
    end else begin
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t unexpected result transfer", $realtime);
        end else begin
          exp_r = outcome_q.pop_front();
          if (exp_r.is_match) match_total++;
          report("is_match", exp_r.is_match, result_i.is_match);
          report("echo_counter", exp_r.echo_counter, result_i.echo_counter);
          report("echo_index", exp_r.echo_index, result_i.echo_index);
          report("masked_key_0", exp_r.masked_key_0, result_i.masked_key_0);
          report("masked_key_1", exp_r.masked_key_1, result_i.masked_key_1);
          report("masked_key_2", exp_r.masked_key_2, result_i.masked_key_2);
          report("masked_key_3", exp_r.masked_key_3, result_i.masked_key_3);
        end
      end
      if (start_i && !busy_i)
        outcome_q.push_back(grade_candidate(item_i.counter_value, item_i.mask_index,
                                            format_cfg, cipher_cfg));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CIPHER_HIGH: cipher_cfg[0:7] = cfg_data_i;
          CFG_CIPHER_LOW:  cipher_cfg[8:15] = cfg_data_i;
          CFG_KEY_FORMAT:  format_cfg = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: tb/aes256_key_candidate_test_test.sv
// Testbench top: clock, reset, candidate and register stimulus, and the verdict
`timescale 1ns / 100ps
module aes256_key_candidate_test_test;
  import aeskct_pkg::*;
  import aes256_key_candidate_test_model_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 3000;

  logic        clk_i, rst_ni, start_i, busy_o, done_o, cfg_we_i;
  in_t         item_i;
  out_t        result_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  int          fail_count, pending, match_count;
  int          sent, burst_left, stall_cycles, phases;
  logic        fmt_now;

  aes256_key_candidate_test DUT (.*);

  aes256_key_candidate_test_checker CHK (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .item_i, .done_i(done_o),
    .result_i(result_o), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .match_count_o(match_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("aes256_key_candidate_test verification failed");
      $finish;
    end
  end

  task automatic send_candidate(logic [31:0] ctr, logic [7:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        start_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    start_i = 1'b1;
    item_i.counter_value = ctr;
    item_i.mask_index = idx;
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  task automatic drain;
    @(negedge clk_i);
    start_i = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Encrypt a zero block under the candidate's key so that it matches.
  task automatic plant_match(logic [31:0] ctr, logic [7:0] idx);
    aes_state_t c;
    c = encrypt_block(masked_key(ctr, idx, fmt_now), '0);
    write_reg(CFG_CIPHER_HIGH, c[0:7]);
    write_reg(CFG_CIPHER_LOW, c[8:15]);
  endtask

  function automatic logic [7:0] pick_index();
    return ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 254));
  endfunction

  initial begin
    logic [31:0] hit_ctr;
    logic [7:0]  hit_idx;
    start_i = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    sent = 0;
    burst_left = 0;
    stall_cycles = 0;
    phases = 0;
    fmt_now = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_candidate(32'h0000_0000, 8'd0);
    send_candidate(32'hffff_ffff, 8'd254);
    send_candidate(32'h0123_abcd, 8'd255);
    send_candidate(32'h89ab_cdef, 8'd1);
    send_candidate(32'h5a5a_a5a5, 8'd127);
    drain();

    write_reg(CFG_CIPHER_HIGH, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_CIPHER_LOW, 64'h0123_4567_89ab_cdef);
    write_reg(CFG_KEY_FORMAT, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_SPARE, 64'hdead_beef_dead_beef);
    fmt_now = 1'b1;
    send_candidate(32'h0000_0000, 8'd255);
    send_candidate(32'hffff_ffff, 8'd0);
    send_candidate(32'h8000_0001, 8'd254);
    send_candidate(32'h7fff_fffe, 8'd128);
    drain();

    for (int f = 0; f < 2; f++) begin
      write_reg(CFG_KEY_FORMAT, f[0] ? 64'h1 : 64'hffff_ffff_ffff_fffe);
      fmt_now = f[0];
      plant_match(32'hc0de_0042, 8'd17);
      send_candidate(32'hc0de_0042, 8'd17);
      send_candidate(32'hc0de_0043, 8'd17);
      send_candidate(32'hc0de_0042, 8'd18);
      drain();
      plant_match(32'h1234_5678, 8'd0);
      send_candidate(32'h1234_5678, 8'd255);
      send_candidate(32'h1234_5678, 8'd0);
      drain();
    end

    for (int p = 0; p < 8; p++) begin
      phases++;
      fmt_now = $urandom_range(0, 1);
      write_reg(CFG_KEY_FORMAT, {$urandom, $urandom});
      write_reg(CFG_KEY_FORMAT, {63'h0, fmt_now});
      case (p)
        0: begin
          write_reg(CFG_CIPHER_HIGH, 64'h0);
          write_reg(CFG_CIPHER_LOW, 64'h0);
        end
        1: begin
          write_reg(CFG_CIPHER_HIGH, 64'hffff_ffff_ffff_ffff);
          write_reg(CFG_CIPHER_LOW, 64'hffff_ffff_ffff_ffff);
        end
        default: begin
          write_reg(CFG_CIPHER_HIGH, {$urandom, $urandom});
          write_reg(CFG_CIPHER_LOW, {$urandom, $urandom});
        end
      endcase
      hit_ctr = $urandom;
      hit_idx = pick_index();
      if (p >= 2) plant_match(hit_ctr, hit_idx);
      for (int n = 0; n < 205; n++) begin
        if (p >= 2 && $urandom_range(0, 19) == 0) send_candidate(hit_ctr, hit_idx);
        else send_candidate($urandom, pick_index());
      end
      drain();
    end

    repeat (40) @(negedge clk_i);
    $display("%0d candidates over %0d random register settings, %0d matches seen",
             sent, phases, match_count);
    $display("both key formats, mask indexes 0 to 255, spare register index written");
    if (fail_count == 0 && pending == 0) begin
      $display("aes256_key_candidate_test verification clean");
    end else begin
      $display("aes256_key_candidate_test verification failed");
    end
    $finish;
  end
endmodule
